[rtl/core/mdpms_pkg.sv]
`default_nettype none

package mdpms_pkg;

    localparam int SCORE_BITS = 48;

    typedef logic signed [SCORE_BITS-1:0] t_score;

    localparam t_score SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_score SCORE_MIN = 48'sh8000_0000_0000;
    localparam logic signed [63:0] SCORE_MAX_W = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SCORE_MIN_W = 64'shFFFF_8000_0000_0000;

    // -1.0 and 0.5 in q.30
    localparam t_score MINUS_ONE       = -48'sd1073741824;
    localparam t_score THRESHOLD_RESET = 48'sd536870912;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_VALID = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

[rtl/core/max_dot_product_match_search_top.sv]
// load and query words: one per cycle, busy stays low, no result
// search word (query element with last mark): walk over all records in index order,
//   DIM table reads for a valid record, one per cycle, an invalid one skipped; then a drain until the pipeline is empty
// busy covers walk and drain; the strobe rises in the same cycle that busy falls,
//   lasts one cycle, the receiver cannot stall, and start is taken again then
// reset clears the valid marks and sets the threshold to 0.5; table and query buffer
//   hold nothing defined until written, no clearing pass
`default_nettype none

module max_dot_product_match_search_top #(
    parameter int RECORDS   = 64,
    parameter int DIM       = 512,
    parameter int ELEM_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_operation,
    input  wire logic [5:0]               i_record_index,
    input  wire logic [8:0]               i_element_index,
    input  wire logic signed [15:0]       i_element_value,
    input  wire logic                     i_valid_flag,
    input  wire logic                     i_query_last,
    input  wire logic                     i_cfg_we,
    input  wire logic signed [47:0]       i_cfg_wdata,
    output logic                          o_strobe,
    output logic [5:0]                    o_best_index,
    output mdpms_pkg::t_score             o_best_score,
    output logic                          o_found,
    output logic                          o_matched
);
    import mdpms_pkg::*;

    localparam int RW    = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int DEPTH = RECORDS * DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * ELEM_BITS;

    t_state r_state, n_state;

    // storage
    logic [ELEM_BITS-1:0] r_table [DEPTH];
    logic [ELEM_BITS-1:0] r_query [DIM];
    logic [RECORDS-1:0]   r_rec_vld;
    t_score               r_threshold;

    logic signed [ELEM_BITS-1:0] r_tab_q, r_qry_q;

    // walk counters
    logic [RW-1:0] r_rec;
    logic [DW-1:0] r_el;
    logic [AW-1:0] r_addr;

    // pipeline
    logic                 r_s1_v, r_s2_v, r_s3_v, r_sc_v;
    logic                 r_s1_last, r_s2_last, r_s3_last;
    logic [RW-1:0]        r_s1_rec, r_s2_rec, r_s3_rec, r_sc_rec;
    logic signed [PW-1:0] r_prod;
    t_score               r_pc, r_acc, r_sc;

    // best so far
    t_score        r_best;
    logic [RW-1:0] r_best_idx;
    logic          r_found;

    logic          r_strobe;
    logic [5:0]    r_out_idx;
    t_score        r_out_score;
    logic          r_out_found, r_out_match;

    logic                 accept, rec_ok, el_ok;
    logic                 tab_we, qry_we, go;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          val32;
    logic [ELEM_BITS-1:0] wr_val;
    logic                 issue, skip, el_last, rec_last, walk_end, empty, emit;
    logic signed [63:0]   prod_w;
    t_score               prod_c;
    logic signed [SCORE_BITS:0] sum_w;
    t_score               sum_s;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign rec_ok   = (32'(i_record_index) < RECORDS);
    assign el_ok    = (32'(i_element_index) < DIM);
    assign tab_we   = accept && (i_operation == OP_WRITE) && rec_ok && el_ok;
    assign qry_we   = accept && (i_operation == OP_QUERY) && el_ok;
    assign go       = accept && (i_operation == OP_QUERY) && i_query_last;
    assign wr_addr  = AW'(32'(i_record_index) * DIM + 32'(i_element_index));
    // upper bits stay zero when the element is wider than the port
    assign val32    = {16'd0, i_element_value};
    assign wr_val   = val32[ELEM_BITS-1:0];

    assign el_last  = (r_el == DW'(DIM - 1));
    assign rec_last = (r_rec == RW'(RECORDS - 1));
    assign empty    = !r_s1_v && !r_s2_v && !r_s3_v && !r_sc_v;

    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        skip     = 1'b0;
        walk_end = 1'b0;
        emit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (go) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_rec_vld[r_rec]) begin
                    issue    = 1'b1;
                    walk_end = el_last && rec_last;
                end else begin
                    skip     = 1'b1;
                    walk_end = rec_last;
                end
                if (walk_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (empty) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories, registered read
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_table[wr_addr] <= wr_val;
        end
        r_tab_q <= r_table[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (qry_we) begin
            r_query[DW'(i_element_index)] <= wr_val;
        end
        r_qry_q <= r_query[r_el];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_vld   <= '0;
            r_threshold <= THRESHOLD_RESET;
        end else begin
            if (accept && (i_operation == OP_VALID) && rec_ok) begin
                r_rec_vld[RW'(i_record_index)] <= i_valid_flag;
            end
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
        end
    end

    // walk over records, linear table address
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rec  <= '0;
            r_el   <= '0;
            r_addr <= '0;
        end else if (issue) begin
            r_addr <= r_addr + AW'(1);
            if (el_last) begin
                r_el  <= '0;
                r_rec <= r_rec + RW'(1);
            end else begin
                r_el <= r_el + DW'(1);
            end
        end else if (skip) begin
            r_addr <= AW'(32'(r_addr) + DIM);
            r_rec  <= r_rec + RW'(1);
        end
    end

    assign prod_w = 64'(r_prod);
    always_comb begin
        if (prod_w > SCORE_MAX_W) begin
            prod_c = SCORE_MAX;
        end else if (prod_w < SCORE_MIN_W) begin
            prod_c = SCORE_MIN;
        end else begin
            prod_c = prod_w[SCORE_BITS-1:0];
        end
    end

    assign sum_w = {r_acc[SCORE_BITS-1], r_acc} + {r_pc[SCORE_BITS-1], r_pc};
    always_comb begin
        if (sum_w[SCORE_BITS] != sum_w[SCORE_BITS-1]) begin
            sum_s = sum_w[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
        end else begin
            sum_s = sum_w[SCORE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_sc_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_sc_v <= r_s3_v && r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= el_last;
        r_s1_rec  <= r_rec;
        r_prod    <= r_tab_q * r_qry_q;
        r_s2_last <= r_s1_last;
        r_s2_rec  <= r_s1_rec;
        r_pc      <= prod_c;
        r_s3_last <= r_s2_last;
        r_s3_rec  <= r_s2_rec;
        if (go) begin
            r_acc <= '0;
        end else if (r_s3_v) begin
            if (r_s3_last) begin
                r_acc    <= '0;
                r_sc     <= sum_s;
                r_sc_rec <= r_s3_rec;
            end else begin
                r_acc <= sum_s;
            end
        end
    end

    // strictly greater, so the earliest record keeps a tie
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_best     <= MINUS_ONE;
            r_best_idx <= '0;
            r_found    <= 1'b0;
        end else begin
            if (issue) begin
                r_found <= 1'b1;
            end
            if (r_sc_v && (r_sc > r_best)) begin
                r_best     <= r_sc;
                r_best_idx <= r_sc_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx   <= 6'(r_best_idx);
            r_out_score <= r_best;
            r_out_found <= r_found;
            r_out_match <= (r_best >= r_threshold);
        end
    end

    assign o_strobe     = r_strobe;
    assign o_best_index = r_out_idx;
    assign o_best_score = r_out_score;
    assign o_found      = r_out_found;
    assign o_matched    = r_out_match;

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a preceding search");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_QUERY) && i_query_last) |=> busy)
        else $error("search word did not start a walk");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> ((o_best_score == MINUS_ONE) && (o_best_index == 6'd0)))
        else $error("result without valid records is not the empty result");

endmodule

`default_nettype wire

[dv/mdpms_match_checker.sv]
module mdpms_match_checker #(
    parameter int RECORDS = 64,
    parameter int DIM     = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [1:0]              i_operation,
    input  logic [5:0]              i_record_index,
    input  logic [8:0]              i_element_index,
    input  logic signed [15:0]      i_element_value,
    input  logic                    i_valid_flag,
    input  logic                    i_query_last,
    input  logic                    i_cfg_we,
    input  logic signed [47:0]      i_cfg_wdata,
    input  logic                    i_strobe,
    input  logic [5:0]              i_best_index,
    input  mdpms_pkg::t_score       i_best_score,
    input  logic                    i_found,
    input  logic                    i_matched,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mdpms_pkg::*;

    typedef struct packed {
        logic [5:0] idx;
        t_score     score;
        logic       found;
        logic       matched;
    } t_match;

    logic signed [15:0] feat_mem [RECORDS][DIM];
    logic               rec_valid [RECORDS];
    logic signed [15:0] query_mem [DIM];
    t_score             threshold;
    t_match             pending_matches [$];
    int                 n_fail = 0;

    function automatic t_score sat_score(longint v);
        if (v > SCORE_MAX_W) return SCORE_MAX;
        if (v < SCORE_MIN_W) return SCORE_MIN;
        return t_score'(v);
    endfunction

    // walk valid records in index order, strictly greater wins
    function automatic t_match best_match();
        t_match m;
        longint acc;
        m.idx   = '0;
        m.score = MINUS_ONE;
        m.found = 1'b0;
        for (int r = 0; r < RECORDS; r++) begin
            if (rec_valid[r]) begin
                m.found = 1'b1;
                acc = 0;
                for (int e = 0; e < DIM; e++)
                    acc = sat_score(acc + sat_score(longint'(feat_mem[r][e])
                                                    * longint'(query_mem[e])));
                if (acc > m.score) begin
                    m.score = t_score'(acc);
                    m.idx   = 6'(r);
                end
            end
        end
        m.matched = (m.score >= threshold);
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            foreach (rec_valid[r]) rec_valid[r] = 1'b0;
            threshold = THRESHOLD_RESET;
            pending_matches.delete();
        end else begin
            if (i_cfg_we)
                threshold = i_cfg_wdata;
            if (i_strobe) begin
                if (pending_matches.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result: idx %0d score %0d found %0b matched %0b",
                                 i_best_index, i_best_score, i_found, i_matched);
                end else begin
                    want = pending_matches.pop_front();
                    if (i_best_index !== want.idx || i_best_score !== want.score
                            || i_found !== want.found || i_matched !== want.matched) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch: exp %0d %0d %0b %0b, got %0d %0d %0b %0b",
                                     want.idx, want.score, want.found, want.matched,
                                     i_best_index, i_best_score, i_found, i_matched);
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_operation)
                    OP_WRITE: begin
                        if (i_record_index < RECORDS && i_element_index < DIM)
                            feat_mem[i_record_index][i_element_index] = i_element_value;
                    end
                    OP_VALID: begin
                        if (i_record_index < RECORDS)
                            rec_valid[i_record_index] = i_valid_flag;
                    end
                    OP_QUERY: begin
                        if (i_element_index < DIM)
                            query_mem[i_element_index] = i_element_value;
                        if (i_query_last)
                            pending_matches = {pending_matches, best_match()};
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= pending_matches.size();
    end

endmodule

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mdpms_pkg::*;

    localparam int RECORDS        = 64;
    localparam int DIM            = 512;
    localparam int N_RANDOM       = 400;
    localparam int WATCHDOG_LIMIT = 200000;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam t_score TOP_SCORE = 48'sd549755813888;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         rec;
        logic [8:0]         el;
        logic signed [15:0] val;
        logic               vflag;
        logic               last;
    } t_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic [5:0]         i_record_index;
    logic [8:0]         i_element_index;
    logic signed [15:0] i_element_value;
    logic               i_valid_flag;
    logic               i_query_last;
    logic               i_cfg_we;
    logic signed [47:0] i_cfg_wdata;
    logic               o_strobe;
    logic [5:0]         o_best_index;
    t_score             o_best_score;
    logic               o_found;
    logic               o_matched;

    int fail_count;
    int pending;
    int idle_run = 0;
    bit gaps_on  = 1'b1;

    always #2 i_clk = ~i_clk;

    max_dot_product_match_search_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_record_index  (i_record_index),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_valid_flag    (i_valid_flag),
        .i_query_last    (i_query_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_best_index    (o_best_index),
        .o_best_score    (o_best_score),
        .o_found         (o_found),
        .o_matched       (o_matched)
    );

    mdpms_match_checker #(.RECORDS(RECORDS), .DIM(DIM)) match_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (i_operation),
        .i_record_index  (i_record_index),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_valid_flag    (i_valid_flag),
        .i_query_last    (i_query_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_strobe        (o_strobe),
        .i_best_index    (o_best_index),
        .i_best_score    (o_best_score),
        .i_found         (o_found),
        .i_matched       (o_matched),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // cycles with neither a word taken nor a result out
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    function automatic t_word word_of(logic [1:0] op, int rec, int el,
                                      logic signed [15:0] val, logic vf, logic last);
        t_word w;
        w.op    = op;
        w.rec   = 6'(rec);
        w.el    = 9'(el);
        w.val   = val;
        w.vflag = vf;
        w.last  = last;
        return w;
    endfunction

    function automatic logic signed [15:0] any_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // record contents for the initial load: a few records have fixed patterns
    function automatic logic signed [15:0] load_value(int r, int e);
        case (r)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return (e == 0) ? 16'sh7FFF : (e == 1) ? 16'sh0001 : 16'sh0000;
            3, 4: return 16'shFFFF;
            5: return 16'sh0000;
            default: return any_value();
        endcase
    endfunction

    function automatic t_word random_word();
        int pick;
        t_word w;
        pick = $urandom_range(99);
        w = word_of(OP_WRITE, $urandom, $urandom, any_value(), 1'($urandom), 1'($urandom));
        if (pick < 45) begin
            w.op = OP_WRITE;
        end else if (pick < 60) begin
            w.op    = OP_VALID;
            w.vflag = ($urandom_range(2) == 0);
        end else if (pick < 85) begin
            w.op   = OP_QUERY;
            w.last = 1'b0;
        end else if (pick < 95) begin
            w.op   = OP_QUERY;
            w.last = 1'b1;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start           = 1'b0;
            i_operation     = 2'($urandom);
            i_record_index  = 6'($urandom);
            i_element_index = 9'($urandom);
            i_element_value = 16'($urandom);
            i_valid_flag    = 1'($urandom);
            i_query_last    = 1'($urandom);
            @(posedge i_clk);
        end
    endtask

    // hold the word until taken; start may drop for a while during a search
    task automatic send_word(t_word w);
        if (gaps_on && $urandom_range(3) == 0)
            idle_cycles($urandom_range(4, 1));
        forever begin
            @(negedge i_clk);
            start           = 1'b1;
            i_operation     = w.op;
            i_record_index  = w.rec;
            i_element_index = w.el;
            i_element_value = w.val;
            i_valid_flag    = w.vflag;
            i_query_last    = w.last;
            @(posedge i_clk);
            while (busy && !(gaps_on && $urandom_range(31) == 0))
                @(posedge i_clk);
            if (!busy)
                break;
            idle_cycles($urandom_range(4, 1));
        end
    endtask

    task automatic search();
        send_word(word_of(OP_QUERY, $urandom, DIM - 1, 16'sh8000, 1'($urandom), 1'b1));
    endtask

    task automatic mark(int r, logic v);
        send_word(word_of(OP_VALID, r, $urandom, any_value(), v, 1'($urandom)));
    endtask

    task automatic set_threshold(t_score v);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        longint thr_raw;
        int     n;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_operation     = OP_WRITE;
        i_record_index  = '0;
        i_element_index = '0;
        i_element_value = '0;
        i_valid_flag    = 1'b0;
        i_query_last    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // load every table word and the whole query buffer before any search
        for (int r = 0; r < RECORDS; r++)
            for (int e = 0; e < DIM; e++)
                send_word(word_of(OP_WRITE, r, e, load_value(r, e), 1'($urandom),
                                  1'($urandom)));
        for (int e = 0; e < DIM; e++)
            send_word(word_of(OP_QUERY, $urandom, e, 16'sh8000, 1'($urandom), 1'b0));

        // directed: empty table, starting-score tie, record tie, top score, thresholds at and above it
        send_word(word_of(OP_UNUSED, $urandom, $urandom, any_value(), 1'($urandom), 1'b1));
        search();
        mark(1, 1'b1);
        mark(2, 1'b1);
        search();
        mark(3, 1'b1);
        mark(4, 1'b1);
        mark(5, 1'b1);
        search();
        mark(0, 1'b1);
        search();
        set_threshold(TOP_SCORE);
        search();
        set_threshold(TOP_SCORE + 48'sd1);
        search();
        set_threshold(SCORE_MAX);
        search();
        for (int r = 0; r <= 5; r++)
            mark(r, 1'b0);
        set_threshold(SCORE_MIN);
        search();

        // random phases, each under its own threshold; the last has no gaps
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: set_threshold('0);
                3: set_threshold(THRESHOLD_RESET);
                default: begin
                    thr_raw = {$urandom, $urandom};
                    set_threshold(t_score'(thr_raw >>> 29));
                end
            endcase
            gaps_on = (ph < 3);
            n = 0;
            while (n < N_RANDOM / 4) begin
                send_word(random_word());
                n++;
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
